[rtl/bmp2bp_pkg.sv]
// Shared types, codes and pixel classification helpers for the BMP row to bit-plane converter.
// No dependencies; imported by bmp2bp_front, bmp2bp_back and the top level.
`default_nettype none

package bmp2bp_pkg;

  localparam logic [5:0] DEPTH_1  = 6'd1;
  localparam logic [5:0] DEPTH_2  = 6'd2;
  localparam logic [5:0] DEPTH_4  = 6'd4;
  localparam logic [5:0] DEPTH_8  = 6'd8;
  localparam logic [5:0] DEPTH_16 = 6'd16;
  localparam logic [5:0] DEPTH_24 = 6'd24;
  localparam logic [5:0] DEPTH_32 = 6'd32;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_DATA    = 1'b1;

  localparam logic FMT_555 = 1'b0;
  localparam logic FMT_565 = 1'b1;

  localparam logic [7:0] WHITE_LEVEL  = 8'h80;
  localparam logic [7:0] ACCENT_LEVEL = 8'hF0;
  localparam logic [9:0] WHITE_SUM    = 10'd384;

  localparam int QUEUE_DEPTH    = 2;
  localparam int SHADOW_ENTRIES = 16;

  typedef enum logic [1:0] {
    REG_BIT_DEPTH       = 2'd0,
    REG_BITFIELD_FORMAT = 2'd1,
    REG_COLOR_ENABLE    = 2'd2,
    REG_ROW_WIDTH       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0]  bit_depth;
    logic        bitfield_format;
    logic        color_enable;
    logic [10:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic       row_end;
    logic [7:0] value;
    logic       white;
    logic       accent;
  } item_t;

  function automatic logic color_on(input cfg_t c);
    return c.color_enable && (c.bit_depth != DEPTH_1);
  endfunction

  function automatic logic is_white(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic col);
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (col) begin
      return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    end
    return sum > WHITE_SUM;
  endfunction

  function automatic logic is_accent(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    return (r > ACCENT_LEVEL) || ((g > ACCENT_LEVEL) && (b > ACCENT_LEVEL));
  endfunction

endpackage

`default_nettype wire

[rtl/bmp2bp_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module bmp2bp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/bmp2bp_front.sv]
// Front end: accepts input transfers, classifies palette entries and queues items.
// Depends on bmp2bp_pkg.
`default_nettype none

module bmp2bp_front
  import bmp2bp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       in_row_end,
  input  logic [7:0] in_pal_index,
  input  logic [7:0] in_pal_red,
  input  logic [7:0] in_pal_green,
  input  logic [7:0] in_pal_blue,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW:0] FULL = (PW + 1)'(QUEUE_DEPTH);

  item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  item_t         item_in;
  logic          push;

  always_comb begin
    item_in.req_type = in_req_type;
    item_in.row_end  = in_row_end;
    item_in.value    = (in_req_type == REQ_DATA) ? in_data_byte : in_pal_index;
    item_in.white    = is_white(in_pal_red, in_pal_green, in_pal_blue, color_on(cfg));
    item_in.accent   = is_accent(in_pal_red, in_pal_green, in_pal_blue);
  end

  assign in_ready = (count_r != FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW + 1)'(push) - (PW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

[rtl/bmp2bp_back.sv]
// Back end: palette store, pixel decode and packing, and the result register.
// Depends on bmp2bp_pkg and bmp2bp_ram.
`default_nettype none

module bmp2bp_back
  import bmp2bp_pkg::*;
#(
  parameter int MAX_ROW_WIDTH   = 1024,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_mono_byte,
  output logic [7:0] out_color_byte,
  output logic [6:0] out_byte_index,
  output logic       out_last_of_row
);

  localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int LW = ((CW > 11) ? CW : 11) + 1;
  localparam int PW = $clog2(PALETTE_ENTRIES);
  localparam int SW = $clog2(SHADOW_ENTRIES);
  localparam logic [LW-1:0] MAX_W     = LW'(MAX_ROW_WIDTH);
  localparam logic [8:0]    PAL_LIMIT = 9'(PALETTE_ENTRIES);
  localparam logic [8:0]    SH_LIMIT  = 9'(SHADOW_ENTRIES);

  localparam logic [1:0] PH_LOW   = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_ALPHA = 2'd3;

  // issue stage
  logic        b1_valid_r;
  item_t       b1_item_r;
  logic        b2_fire;
  logic        issue;
  logic        pal_we;
  logic [1:0]  pal_rdata;
  logic [1:0]  shadow_r [SHADOW_ENTRIES];

  // row state
  logic [15:0]   gather_r, gather_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    mono_r, mono_nxt;
  logic [7:0]    color_r, color_nxt;

  // result register
  logic       out_valid_r;
  logic [7:0] out_mono_r, out_color_r;
  logic [6:0] out_idx_r;
  logic       out_last_r;

  // decode
  logic [7:0]    d;
  logic [LW-1:0] width_eff;
  logic [LW-1:0] col_ext;
  logic          con;
  logic          indexed;
  logic [3:0]    npix;
  logic          direct_go;
  logic [7:0]    dr, dg, db;
  logic          lane_on [8];
  logic          lane_w  [8];
  logic          lane_a  [8];
  logic          emit;
  logic [7:0]    emit_mono, emit_color;
  logic [6:0]    emit_idx;
  logic          emit_last;

  assign b2_fire = b1_valid_r && (!out_valid_r || out_ready);
  assign issue   = q_valid && (!b1_valid_r || b2_fire);
  assign q_pop   = issue;
  assign pal_we  = issue && (q_item.req_type == REQ_PALETTE) && ({1'b0, q_item.value} < PAL_LIMIT);

  bmp2bp_ram #(
    .WIDTH(2),
    .DEPTH(PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk  (clk),
    .we   (pal_we),
    .waddr(q_item.value[PW-1:0]),
    .wdata({q_item.white, q_item.accent}),
    .re   (issue),
    .raddr(q_item.value[PW-1:0]),
    .rdata(pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (pal_we && ({1'b0, q_item.value} < SH_LIMIT)) begin
      shadow_r[q_item.value[SW-1:0]] <= {q_item.white, q_item.accent};
    end
    if (issue) begin
      b1_item_r <= q_item;
    end
  end

  always_comb begin
    d         = b1_item_r.value;
    con       = color_on(cfg);
    col_ext   = LW'(col_r);
    width_eff = (LW'(cfg.row_width) > MAX_W) ? MAX_W : LW'(cfg.row_width);
    gather_nxt = gather_r;
    phase_nxt  = phase_r;
    indexed    = 1'b0;
    npix       = 4'd0;
    direct_go  = 1'b0;
    dr = 8'h00;
    dg = 8'h00;
    db = 8'h00;
    if ((b1_item_r.req_type == REQ_DATA) && (col_ext < width_eff)) begin
      unique case (cfg.bit_depth) inside
        DEPTH_1: begin
          indexed = 1'b1;
          npix    = 4'd8;
        end
        DEPTH_2: begin
          indexed = 1'b1;
          npix    = 4'd4;
        end
        DEPTH_4: begin
          indexed = 1'b1;
          npix    = 4'd2;
        end
        DEPTH_8: begin
          indexed = 1'b1;
          npix    = 4'd1;
        end
        DEPTH_16: begin
          if (phase_r == PH_MID) begin
            db = {gather_r[4:0], 3'b000};
            if (cfg.bitfield_format == FMT_555) begin
              dg = {d[1:0], gather_r[7:5], 3'b000};
              dr = {d[6:2], 3'b000};
            end else begin
              dg = {d[2:0], gather_r[7:5], 2'b00};
              dr = {d[7:3], 3'b000};
            end
            phase_nxt = PH_LOW;
            direct_go = 1'b1;
          end else begin
            gather_nxt = {8'h00, d};
            phase_nxt  = PH_MID;
          end
        end
        DEPTH_24, DEPTH_32: begin
          case (phase_r)
            PH_LOW: begin
              gather_nxt = {8'h00, d};
              phase_nxt  = PH_MID;
            end
            PH_MID: begin
              gather_nxt = {d, gather_r[7:0]};
              phase_nxt  = PH_HIGH;
            end
            PH_HIGH: begin
              dr = d;
              dg = gather_r[15:8];
              db = gather_r[7:0];
              phase_nxt = (cfg.bit_depth == DEPTH_32) ? PH_ALPHA : PH_LOW;
              direct_go = 1'b1;
            end
            default: begin
              phase_nxt = PH_LOW;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin : lane_decode
    logic [7:0] sh;
    logic [3:0] pn;
    for (int k = 0; k < 8; k++) begin
      sh = 8'h00;
      unique case (cfg.bit_depth)
        DEPTH_1: sh = d << k;
        DEPTH_2: sh = d << (2 * k);
        default: sh = d << (4 * k);
      endcase
      unique case (cfg.bit_depth)
        DEPTH_1: pn = {3'b000, sh[7]};
        DEPTH_2: pn = {2'b00, sh[7:6]};
        default: pn = sh[7:4];
      endcase
      lane_on[k] = indexed && (4'(k) < npix) && ((col_ext + LW'(k)) < width_eff);
      lane_w[k]  = 1'b0;
      lane_a[k]  = 1'b0;
      if (cfg.bit_depth == DEPTH_8) begin
        if ({1'b0, d} < PAL_LIMIT) begin
          {lane_w[k], lane_a[k]} = pal_rdata;
        end
      end else if ({5'b00000, pn} < PAL_LIMIT) begin
        {lane_w[k], lane_a[k]} = shadow_r[pn];
      end
    end
    if (direct_go) begin
      lane_on[0] = 1'b1;
      lane_w[0]  = is_white(dr, dg, db, con);
      lane_a[0]  = is_accent(dr, dg, db);
    end
  end

  always_comb begin : pack
    logic [LW-1:0] colk;
    logic [7:0]    keep;
    logic [3:0]    cnt;
    mono_nxt   = mono_r;
    color_nxt  = color_r;
    emit       = 1'b0;
    emit_mono  = 8'hFF;
    emit_color = 8'hFF;
    emit_idx   = 7'd0;
    emit_last  = 1'b0;
    cnt        = 4'd0;
    for (int k = 0; k < 8; k++) begin
      colk = col_ext + LW'(k);
      keep = ~(8'h80 >> colk[2:0]);
      if (lane_on[k]) begin
        if (!lane_w[k]) begin
          if (lane_a[k] && con) begin
            color_nxt = color_nxt & keep;
          end else begin
            mono_nxt = mono_nxt & keep;
          end
        end
        cnt = cnt + 4'd1;
        if ((colk[2:0] == 3'd7) || ((colk + 1'b1) == width_eff)) begin
          emit       = 1'b1;
          emit_mono  = mono_nxt;
          emit_color = color_nxt;
          emit_idx   = colk[9:3];
          emit_last  = ((colk + 1'b1) == width_eff);
          mono_nxt   = 8'hFF;
          color_nxt  = 8'hFF;
        end
      end
    end
    col_nxt = col_r + CW'(cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gather_r    <= 16'h0000;
      phase_r     <= PH_LOW;
      col_r       <= '0;
      mono_r      <= 8'hFF;
      color_r     <= 8'hFF;
    end else begin
      if (issue) begin
        b1_valid_r <= 1'b1;
      end else if (b2_fire) begin
        b1_valid_r <= 1'b0;
      end
      if (b2_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (b2_fire) begin
        if (b1_item_r.row_end) begin
          gather_r <= 16'h0000;
          phase_r  <= PH_LOW;
          col_r    <= '0;
          mono_r   <= 8'hFF;
          color_r  <= 8'hFF;
        end else begin
          gather_r <= gather_nxt;
          phase_r  <= phase_nxt;
          col_r    <= col_nxt;
          mono_r   <= mono_nxt;
          color_r  <= color_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b2_fire && emit) begin
      out_mono_r  <= emit_mono;
      out_color_r <= emit_color;
      out_idx_r   <= emit_idx;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mono_byte   = out_mono_r;
  assign out_color_byte  = out_color_r;
  assign out_byte_index  = out_idx_r;
  assign out_last_of_row = out_last_r;

endmodule

`default_nettype wire

[rtl/bmp_row_to_bitplanes.sv]
// Top level of the BMP row to bit-plane converter: register port, front end and back end.
// Depends on bmp2bp_pkg, bmp2bp_front, bmp2bp_back and bmp2bp_ram.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------------
//   in_      | in_valid / in_ready    | req_type, data_byte, row_end, pal_index, pal_rgb
//   out_     | out_valid / out_ready  | mono_byte, color_byte, byte_index, last_of_row
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready (always high)
//
// One item per cycle sustained while out_ready is high; each transfer is registered in
// the queue, the palette read and the result register. The palette RAM read port sets
// the issue stage. Synchronous active-low reset clears all row and handshake state;
// palette contents are not cleared. A stalled result holds the back end; the two-entry
// queue keeps in_ready high until it fills.
`default_nettype none

module bmp_row_to_bitplanes
  import bmp2bp_pkg::*;
#(
  parameter int MAX_ROW_WIDTH   = 1024,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic        in_row_end,
  input  logic [7:0]  in_pal_index,
  input  logic [7:0]  in_pal_red,
  input  logic [7:0]  in_pal_green,
  input  logic [7:0]  in_pal_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mono_byte,
  output logic [7:0]  out_color_byte,
  output logic [6:0]  out_byte_index,
  output logic        out_last_of_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int LW = ((CW > 11) ? CW : 11) + 1;
  localparam logic [LW-1:0] MAX_W = LW'(MAX_ROW_WIDTH);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_sel;
  logic     cfg_we;
  logic     q_valid;
  item_t    q_item;
  logic     q_pop;
  logic [LW-1:0] width_eff;
  logic [LW-1:0] width_last;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_sel)
        REG_BIT_DEPTH:       cfg_nxt.bit_depth       = pwdata[5:0];
        REG_BITFIELD_FORMAT: cfg_nxt.bitfield_format = pwdata[0];
        REG_COLOR_ENABLE:    cfg_nxt.color_enable    = pwdata[0];
        REG_ROW_WIDTH:       cfg_nxt.row_width       = pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'h0000_0000;
    unique case (reg_sel)
      REG_BIT_DEPTH:       prdata = {26'h0, cfg_r.bit_depth};
      REG_BITFIELD_FORMAT: prdata = {31'h0, cfg_r.bitfield_format};
      REG_COLOR_ENABLE:    prdata = {31'h0, cfg_r.color_enable};
      REG_ROW_WIDTH:       prdata = {21'h0, cfg_r.row_width};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_depth       <= DEPTH_24;
      cfg_r.bitfield_format <= FMT_555;
      cfg_r.color_enable    <= 1'b1;
      cfg_r.row_width       <= 11'd640;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bmp2bp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_data_byte(in_data_byte),
    .in_row_end  (in_row_end),
    .in_pal_index(in_pal_index),
    .in_pal_red  (in_pal_red),
    .in_pal_green(in_pal_green),
    .in_pal_blue (in_pal_blue),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  bmp2bp_back #(
    .MAX_ROW_WIDTH  (MAX_ROW_WIDTH),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mono_byte  (out_mono_byte),
    .out_color_byte (out_color_byte),
    .out_byte_index (out_byte_index),
    .out_last_of_row(out_last_of_row)
  );

  assign width_eff  = (LW'(cfg_r.row_width) > MAX_W) ? MAX_W : LW'(cfg_r.row_width);
  assign width_last = width_eff - 1'b1;

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("queue blocks input with no item at its head");

  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_row) |-> (out_byte_index == width_last[9:3]))
    else $error("row end flagged at wrong byte position");

endmodule

`default_nettype wire
